FILE: hdl/credential_table_matcher_core_defines.svh
// Assertion macros shared by the credential table matcher RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef CREDENTIAL_TABLE_MATCHER_CORE_DEFINES_SVH
`define CREDENTIAL_TABLE_MATCHER_CORE_DEFINES_SVH

// Invariant that holds at every clock edge
`define CTM_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");

// Same-cycle implication
`define CTM_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// Next-cycle implication
`define CTM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

FILE: hdl/ctm_pkg.sv
// Package for the credential table matcher: sizes, operation codes,
// beat layouts and the structs passed between the top level and the cells.
// No dependencies.
`default_nettype none

package ctm_pkg;

	// Table geometry
	localparam int CAPACITY    = 256;
	localparam int ID_DIGITS   = 8;
	localparam int PASS_DIGITS = 5;

	localparam int ID_W   = 4 * ID_DIGITS;
	localparam int PASS_W = 4 * PASS_DIGITS;
	localparam int LEN_W  = 3;
	localparam int FLR_W  = 8;
	localparam int EIDX_W = 8;
	localparam int OP_W   = 3;
	localparam int FIDX_W = 8;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SEL_W = (IDX_W > EIDX_W) ? IDX_W : EIDX_W;

	// Input beat layout (tdata), lowest field first
	localparam int OFS_ID   = 0;
	localparam int OFS_PASS = OFS_ID + ID_W;
	localparam int OFS_LEN  = OFS_PASS + PASS_W;
	localparam int OFS_FLR  = OFS_LEN + LEN_W;
	localparam int OFS_EIDX = OFS_FLR + FLR_W;
	localparam int S_RAW_W  = OFS_EIDX + EIDX_W;
	localparam int S_DATA_W = ((S_RAW_W + 7) / 8) * 8;

	// Output beat layout (tdata)
	localparam int OFS_FLAG  = 0;
	localparam int OFS_FOUND = 1;
	localparam int OFS_FIDX  = 2;
	localparam int M_RAW_W   = OFS_FIDX + FIDX_W;
	localparam int M_DATA_W  = ((M_RAW_W + 7) / 8) * 8;

	localparam logic [FIDX_W-1:0] NOT_FOUND_INDEX = '1;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CHECK  = 3'd0;
	localparam logic [OP_W-1:0] OP_GET    = 3'd1;
	localparam logic [OP_W-1:0] OP_TOGGLE = 3'd2;
	localparam logic [OP_W-1:0] OP_BLOCK  = 3'd3;
	localparam logic [OP_W-1:0] OP_ADD    = 3'd4;

	// Query held by the top level for the whole pass, seen by every cell
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   card_id;
		logic [PASS_W-1:0] password;
		logic [LEN_W-1:0]  password_length;
		logic [PASS_W-1:0] pass_mask;
		logic [FLR_W-1:0]  floor_number;
		logic [EIDX_W-1:0] entry_index;
	} query_t;

	// Token handed from cell to cell
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [IDX_W-1:0] idx;
	} tok_t;

	// Mask over the leading min(len, PASS_DIGITS) digits of the password word
	function automatic logic [PASS_W-1:0] pass_mask(input logic [LEN_W-1:0] len);
		logic [PASS_W-1:0] m;
		m = '0;
		for (int d = 0; d < PASS_DIGITS; d++) begin
			if (int'(len) > d) begin
				m[PASS_W-1-4*d -: 4] = 4'hf;
			end
		end
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/credential_table_matcher_core.sv
// Credential table matcher top level: input/output stream registers, the
// query register, entry count and a chain of ctm_cell entries.
// Depends on ctm_pkg, ctm_cell and credential_table_matcher_core_defines.svh.
//
// Channel | Dir | Beat contents (lowest bits first)
// s_*     | in  | tuser: operation; tdata: card_id, password, password_length,
//         |     |        floor_number, entry_index, zero pad to 72 bits
// m_*     | out | tdata: result_flag, found, found_index, zero pad to 16 bits
//
// Each request is accepted into the launch register, walks the entry chain
// through the token stage of every cell, then loads the result register.
// One request is in flight at a time; s_tready is high whenever the chain is
// empty, even while a result still waits in the output register.
// A held result stalls the token at the chain tail until m_tready is seen.
// Reset clears the entry count and all control; entry contents are not cleared.
`default_nettype none
`include "credential_table_matcher_core_defines.svh"

module credential_table_matcher_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// card_id, password, password_length, floor_number, entry_index
	input  logic [ctm_pkg::S_DATA_W-1:0] s_tdata,
	// operation
	input  logic [ctm_pkg::OP_W-1:0]     s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// result_flag, found, found_index
	output logic [ctm_pkg::M_DATA_W-1:0] m_tdata
);
	import ctm_pkg::*;

	logic              busy_q;
	logic [CNT_W-1:0]  count_q;
	query_t            query_q;
	tok_t              launch_q;
	tok_t              chain [CAPACITY+1];
	logic [CAPACITY:0] vld_vec;
	tok_t              tail;

	logic              m_tvalid_q;
	logic              flag_q;
	logic              found_q;
	logic [FIDX_W-1:0] fidx_q;

	logic s_acc, adv, done, res_found;

	assign s_tready = !busy_q;
	assign s_acc    = s_tvalid && !busy_q;
	assign tail     = chain[CAPACITY];
	assign adv      = !tail.vld || !m_tvalid_q || m_tready;
	assign done     = tail.vld && adv;

	// Query capture on an accepted beat
	always_ff @(posedge clk) begin
		if (s_acc) begin
			query_q.op              <= s_tuser;
			query_q.card_id         <= s_tdata[OFS_ID +: ID_W];
			query_q.password        <= s_tdata[OFS_PASS +: PASS_W];
			query_q.password_length <= s_tdata[OFS_LEN +: LEN_W];
			query_q.pass_mask       <= pass_mask(s_tdata[OFS_LEN +: LEN_W]);
			query_q.floor_number    <= s_tdata[OFS_FLR +: FLR_W];
			query_q.entry_index     <= s_tdata[OFS_EIDX +: EIDX_W];
		end
	end

	// Busy flag, token launch and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= '0;
			count_q  <= '0;
		end else begin
			if (adv) begin
				launch_q.vld <= s_acc;
				launch_q.hit <= 1'b0;
				launch_q.idx <= '0;
			end
			if (s_acc) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done && query_q.op == OP_ADD && tail.hit) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	assign chain[0] = launch_q;

	// Entry chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ctm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.cell_idx (IDX_W'(i)),
			.count    (count_q),
			.query    (query_q),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1])
		);
	end

	always_comb begin
		for (int k = 0; k <= CAPACITY; k++) begin
			vld_vec[k] = chain[k].vld;
		end
	end

	// Result register
	assign res_found = (query_q.op == OP_GET) && tail.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			flag_q  <= tail.hit && ((query_q.op == OP_CHECK) ||
				(query_q.op == OP_TOGGLE) || (query_q.op == OP_ADD));
			found_q <= res_found;
			fidx_q  <= res_found ? FIDX_W'(tail.idx) : NOT_FOUND_INDEX;
		end
	end

	assign m_tvalid = m_tvalid_q;

	always_comb begin
		m_tdata                       = '0;
		m_tdata[OFS_FLAG]             = flag_q;
		m_tdata[OFS_FOUND]            = found_q;
		m_tdata[OFS_FIDX +: FIDX_W]   = fidx_q;
	end

	// Checks
	`CTM_ASSERT(a_single_token, $countones(vld_vec) <= 1)
	`CTM_ASSERT_IMPL(a_idle_chain_empty, !busy_q, vld_vec == '0)
	`CTM_ASSERT(a_count_bound, int'(count_q) <= CAPACITY)
	`CTM_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, busy_q)
	`CTM_ASSERT_NEXT(a_add_count, done && query_q.op == OP_ADD && tail.hit, count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

FILE: hdl/ctm_cell.sv
// One table entry of the credential table matcher and its token stage.
// Depends on ctm_pkg.
`default_nettype none

module ctm_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic [ctm_pkg::IDX_W-1:0] cell_idx,
	input  logic [ctm_pkg::CNT_W-1:0] count,
	input  ctm_pkg::query_t           query,
	input  ctm_pkg::tok_t             tok_in,
	output ctm_pkg::tok_t             tok_out
);
	import ctm_pkg::*;

	// Entry contents, undefined until the add that writes them
	logic [ID_W-1:0]   id_q;
	logic [PASS_W-1:0] pass_q;
	logic [LEN_W-1:0]  len_q;
	logic [FLR_W-1:0]  floor_q;
	logic              inside_q;
	logic              blocked_q;

	tok_t tok_q;

	logic live, is_tail, sel, id_eq, pw_eq, act;
	logic new_hit, do_toggle, do_block, do_add;

	// Entry decode against the query
	assign live    = CNT_W'(cell_idx) < count;
	assign is_tail = CNT_W'(cell_idx) == count;
	assign sel     = SEL_W'(cell_idx) == SEL_W'(query.entry_index);
	assign id_eq   = id_q == query.card_id;
	assign pw_eq   = (len_q == query.password_length) &&
		(((pass_q ^ query.password) & query.pass_mask) == '0);
	assign act     = tok_in.vld && adv;

	// Per-operation action of this cell
	always_comb begin
		new_hit   = 1'b0;
		do_toggle = 1'b0;
		do_block  = 1'b0;
		do_add    = 1'b0;
		case (query.op)
			OP_CHECK: begin
				new_hit = !tok_in.hit && live && !blocked_q && id_eq && pw_eq;
			end
			OP_GET: begin
				new_hit = !tok_in.hit && live && id_eq;
			end
			OP_TOGGLE: begin
				do_toggle = live && sel;
			end
			OP_BLOCK: begin
				do_block = live && sel;
			end
			OP_ADD: begin
				do_add = is_tail;
			end
			default: begin
			end
		endcase
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (act && do_add) begin
			id_q      <= query.card_id;
			pass_q    <= query.password;
			len_q     <= query.password_length;
			floor_q   <= query.floor_number;
			inside_q  <= 1'b0;
			blocked_q <= 1'b0;
		end else begin
			if (act && do_toggle) begin
				inside_q <= !inside_q;
			end
			if (act && do_block) begin
				blocked_q <= 1'b1;
			end
		end
	end

	// Token stage toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q.vld <= tok_in.vld;
			tok_q.hit <= tok_in.hit || new_hit || do_add || (do_toggle && !inside_q);
			tok_q.idx <= new_hit ? cell_idx : tok_in.idx;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire
